>>> rtl/snml_pkg.sv
// Shared types, codes and constants for the star network master link block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package snml_pkg;

	localparam int TIMER_BITS = 16;
	localparam int WAIT_BITS  = 16;
	localparam int CMP_BITS   = (TIMER_BITS > WAIT_BITS) ? TIMER_BITS : WAIT_BITS;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	localparam logic [7:0] FRAME_BYTES = 8'd8;

	// result queue
	localparam int QDEPTH    = 3;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	// opcodes
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_FRAME   = 2'd1;
	localparam logic [1:0] OP_TX_DONE = 2'd2;

	// link states
	localparam logic [1:0] ST_RESET    = 2'd0;
	localparam logic [1:0] ST_RECEIVE  = 2'd1;
	localparam logic [1:0] ST_TRANSMIT = 2'd2;

	// event kinds
	localparam logic [2:0] EV_START_RX  = 3'd0;
	localparam logic [2:0] EV_SEND_ACK  = 3'd1;
	localparam logic [2:0] EV_READING   = 3'd2;
	localparam logic [2:0] EV_CRC_ERROR = 3'd3;
	localparam logic [2:0] EV_RX_WAIT   = 3'd4;
	localparam logic [2:0] EV_TX_GIVEUP = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_MASTER_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_SLAVE_COUNT    = 2'd1;
	localparam logic [1:0] CFG_RX_WAIT_TICKS  = 2'd2;
	localparam logic [1:0] CFG_TX_WAIT_TICKS  = 2'd3;

	localparam logic [7:0]           RST_MASTER_ADDRESS = 8'd0;
	localparam logic [7:0]           RST_SLAVE_COUNT    = 8'd3;
	localparam logic [WAIT_BITS-1:0] RST_RX_WAIT_TICKS  = WAIT_BITS'(5 * 1000);
	localparam logic [WAIT_BITS-1:0] RST_TX_WAIT_TICKS  = WAIT_BITS'(3 * 1000);

	typedef struct packed {
		logic [1:0]  opcode;
		logic        crc_bad;
		logic [7:0]  frame_length;
		logic [7:0]  frame_dest;
		logic [7:0]  frame_source;
		logic [7:0]  frame_sensor_kind;
		logic [7:0]  frame_sequence;
		logic [7:0]  frame_channel;
		logic [15:0] frame_value;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  ack_dest;
		logic [7:0]  ack_source;
		logic [7:0]  ack_sensor_kind;
		logic [7:0]  ack_sequence;
		logic        reading_analog;
		logic        reading_channel;
		logic [15:0] reading_value;
		logic [15:0] total_bytes;
		logic [1:0]  next_state;
	} res_t;

endpackage

>>> rtl/snml_core.sv
// Input stage, configuration registers, link state and transition logic.
// Depends on snml_pkg.
`timescale 1ns / 1ps

module snml_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  snml_pkg::item_t   item,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              pend,
	output logic              res_valid,
	output snml_pkg::res_t    res
);

	logic                               valid_s1;
	snml_pkg::item_t                    item_s1;

	logic [7:0]                         master_address_q;
	logic [7:0]                         slave_count_q;
	logic [snml_pkg::WAIT_BITS-1:0]     rx_wait_q;
	logic [snml_pkg::WAIT_BITS-1:0]     tx_wait_q;

	logic [1:0]                         state_q;
	logic                               rx_flag_q;
	logic                               tx_flag_q;
	logic                               crc_flag_q;
	logic [7:0]                         length_q;
	logic [7:0]                         dest_q;
	logic [7:0]                         source_q;
	logic [7:0]                         kind_q;
	logic [7:0]                         seq_q;
	logic [7:0]                         chan_q;
	logic [15:0]                        value_q;
	logic [snml_pkg::TIMER_BITS-1:0]    rx_el_q;
	logic [snml_pkg::TIMER_BITS-1:0]    tx_el_q;
	logic [15:0]                        total_q;

	logic [1:0]                         state_d;
	logic                               rx_flag_d;
	logic                               tx_flag_d;
	logic                               crc_flag_d;
	logic [snml_pkg::TIMER_BITS-1:0]    rx_el_d;
	logic [snml_pkg::TIMER_BITS-1:0]    tx_el_d;
	logic [15:0]                        total_d;
	logic [snml_pkg::TIMER_BITS-1:0]    rx_b;
	logic [snml_pkg::TIMER_BITS-1:0]    tx_b;
	logic                               frame_ok;
	logic                               fire;
	snml_pkg::res_t                     res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_address_q <= snml_pkg::RST_MASTER_ADDRESS;
			slave_count_q    <= snml_pkg::RST_SLAVE_COUNT;
			rx_wait_q        <= snml_pkg::RST_RX_WAIT_TICKS;
			tx_wait_q        <= snml_pkg::RST_TX_WAIT_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				snml_pkg::CFG_MASTER_ADDRESS: master_address_q <= cfg_data[7:0];
				snml_pkg::CFG_SLAVE_COUNT:    slave_count_q    <= cfg_data[7:0];
				snml_pkg::CFG_RX_WAIT_TICKS:  rx_wait_q        <= cfg_data;
				snml_pkg::CFG_TX_WAIT_TICKS:  tx_wait_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rx_b = (rx_el_q == snml_pkg::TIMER_MAX) ? rx_el_q : rx_el_q + 1'b1;
	assign tx_b = (tx_el_q == snml_pkg::TIMER_MAX) ? tx_el_q : tx_el_q + 1'b1;

	assign frame_ok = !crc_flag_q && rx_flag_q && (length_q == snml_pkg::FRAME_BYTES) &&
		(dest_q == master_address_q) && (source_q != 8'd0) && (source_q <= slave_count_q);

	always_comb begin
		state_d    = state_q;
		rx_flag_d  = rx_flag_q;
		tx_flag_d  = tx_flag_q;
		crc_flag_d = crc_flag_q;
		rx_el_d    = rx_b;
		tx_el_d    = tx_b;
		total_d    = total_q;
		fire       = 1'b0;
		res_d      = '0;
		case (state_q)
			snml_pkg::ST_RESET: begin
				rx_flag_d        = 1'b0;
				rx_el_d          = '0;
				state_d          = snml_pkg::ST_RECEIVE;
				fire             = 1'b1;
				res_d.event_kind = snml_pkg::EV_START_RX;
			end
			snml_pkg::ST_RECEIVE: begin
				if (frame_ok) begin
					rx_flag_d             = 1'b0;
					tx_flag_d             = 1'b0;
					tx_el_d               = '0;
					state_d               = snml_pkg::ST_TRANSMIT;
					fire                  = 1'b1;
					res_d.event_kind      = snml_pkg::EV_SEND_ACK;
					res_d.ack_dest        = source_q;
					res_d.ack_source      = master_address_q;
					res_d.ack_sensor_kind = kind_q;
					res_d.ack_sequence    = seq_q;
				end else if (crc_flag_q) begin
					rx_flag_d        = 1'b0;
					crc_flag_d       = 1'b0;
					state_d          = snml_pkg::ST_RESET;
					fire             = 1'b1;
					res_d.event_kind = snml_pkg::EV_CRC_ERROR;
				end else if (!rx_flag_q &&
					(snml_pkg::CMP_BITS'(rx_b) >= snml_pkg::CMP_BITS'(rx_wait_q))) begin
					rx_el_d          = '0;
					fire             = 1'b1;
					res_d.event_kind = snml_pkg::EV_RX_WAIT;
				end
			end
			default: begin
				if (tx_flag_q) begin
					tx_flag_d             = 1'b0;
					total_d               = total_q + 16'(snml_pkg::FRAME_BYTES);
					rx_el_d               = '0;
					state_d               = snml_pkg::ST_RECEIVE;
					fire                  = 1'b1;
					res_d.event_kind      = snml_pkg::EV_READING;
					res_d.reading_analog  = (kind_q != 8'd0);
					res_d.reading_channel = (chan_q != 8'd0);
					res_d.reading_value   = value_q;
				end else if (snml_pkg::CMP_BITS'(tx_b) >= snml_pkg::CMP_BITS'(tx_wait_q)) begin
					state_d          = snml_pkg::ST_RESET;
					fire             = 1'b1;
					res_d.event_kind = snml_pkg::EV_TX_GIVEUP;
				end
			end
		endcase
		res_d.total_bytes = total_d;
		res_d.next_state  = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= snml_pkg::ST_RESET;
			rx_flag_q  <= 1'b0;
			tx_flag_q  <= 1'b0;
			crc_flag_q <= 1'b0;
			length_q   <= '0;
			dest_q     <= '0;
			source_q   <= '0;
			kind_q     <= '0;
			seq_q      <= '0;
			chan_q     <= '0;
			value_q    <= '0;
			rx_el_q    <= '0;
			tx_el_q    <= '0;
			total_q    <= '0;
		end else if (valid_s1) begin
			case (item_s1.opcode)
				snml_pkg::OP_FRAME: begin
					// latch the whole frame; a late one replaces what is held, but the CRC flag accumulates
					rx_flag_q  <= 1'b1;
					crc_flag_q <= crc_flag_q | item_s1.crc_bad;
					length_q   <= item_s1.frame_length;
					dest_q     <= item_s1.frame_dest;
					source_q   <= item_s1.frame_source;
					kind_q     <= item_s1.frame_sensor_kind;
					seq_q      <= item_s1.frame_sequence;
					chan_q     <= item_s1.frame_channel;
					value_q    <= item_s1.frame_value;
				end
				snml_pkg::OP_TX_DONE: begin
					tx_flag_q <= 1'b1;
				end
				snml_pkg::OP_TICK: begin
					state_q    <= state_d;
					rx_flag_q  <= rx_flag_d;
					tx_flag_q  <= tx_flag_d;
					crc_flag_q <= crc_flag_d;
					rx_el_q    <= rx_el_d;
					tx_el_q    <= tx_el_d;
					total_q    <= total_d;
				end
				default: ;
			endcase
		end
	end

	assign pend      = valid_s1;
	assign res_valid = valid_s1 && (item_s1.opcode == snml_pkg::OP_TICK) && fire;
	assign res       = res_d;

endmodule

>>> rtl/snml_resq.sv
// Small result queue between the transition logic and the output channel.
// Depends on snml_pkg.
`timescale 1ns / 1ps

module snml_resq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  snml_pkg::res_t                  push_data,
	input  logic                            pop,
	output logic                            not_empty,
	output snml_pkg::res_t                  head,
	output logic [snml_pkg::QCNT_BITS-1:0]  count
);

	snml_pkg::res_t                         mem_q [snml_pkg::QDEPTH];
	logic [snml_pkg::QPTR_BITS-1:0]         wr_q;
	logic [snml_pkg::QPTR_BITS-1:0]         rd_q;
	logic [snml_pkg::QCNT_BITS-1:0]         cnt_q;
	logic                                   do_pop;

	function automatic logic [snml_pkg::QPTR_BITS-1:0] adv(
		input logic [snml_pkg::QPTR_BITS-1:0] p);
		adv = (p == snml_pkg::QPTR_BITS'(snml_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= adv(wr_q);
			end
			if (do_pop) begin
				rd_q <= adv(rd_q);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];
	assign count     = cnt_q;

endmodule

>>> rtl/star_net_master_link_fsm_top.sv
// Top level of the star network master link controller.
// Depends on snml_pkg, snml_core and snml_resq.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   in      | in_valid/in_stall  | opcode, crc_bad, frame_* fields
//   out     | out_valid/out_stall| event_kind, ack_*, reading_*, total_bytes,
//           |                    | next_state
//   cfg     | cfg_we             | cfg_index, cfg_data
//
// One transaction per clock while in_stall is low: an event is registered, evaluated in
// the next cycle against the link state, and any result is queued in the same edge, so a
// result passes the input register and the result queue before it appears.
// A three-entry result queue lets input continue while out_stall holds;
// in_stall rises once the queue plus the event in flight would fill it.
// arst_n clears state, counters and flags and restores the register defaults.
`timescale 1ns / 1ps

module star_net_master_link_fsm_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic        crc_bad,
	input  logic [7:0]  frame_length,
	input  logic [7:0]  frame_dest,
	input  logic [7:0]  frame_source,
	input  logic [7:0]  frame_sensor_kind,
	input  logic [7:0]  frame_sequence,
	input  logic [7:0]  frame_channel,
	input  logic [15:0] frame_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_kind,
	output logic [7:0]  ack_dest,
	output logic [7:0]  ack_source,
	output logic [7:0]  ack_sensor_kind,
	output logic [7:0]  ack_sequence,
	output logic        reading_analog,
	output logic        reading_channel,
	output logic [15:0] reading_value,
	output logic [15:0] total_bytes,
	output logic [1:0]  next_state,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	snml_pkg::item_t                        item;
	snml_pkg::res_t                         res;
	snml_pkg::res_t                         head;
	logic                                   res_valid;
	logic                                   pend;
	logic                                   accept;
	logic [snml_pkg::QCNT_BITS-1:0]         count;
	logic [snml_pkg::QCNT_BITS:0]           used;

	assign item.opcode            = opcode;
	assign item.crc_bad           = crc_bad;
	assign item.frame_length      = frame_length;
	assign item.frame_dest        = frame_dest;
	assign item.frame_source      = frame_source;
	assign item.frame_sensor_kind = frame_sensor_kind;
	assign item.frame_sequence    = frame_sequence;
	assign item.frame_channel     = frame_channel;
	assign item.frame_value       = frame_value;

	// reserve a queue slot for the event still in the input stage
	assign used     = {1'b0, count} + {{snml_pkg::QCNT_BITS{1'b0}}, pend};
	assign in_stall = (used >= (snml_pkg::QCNT_BITS + 1)'(snml_pkg::QDEPTH));
	assign accept   = in_valid && !in_stall;

	snml_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pend      (pend),
		.res_valid (res_valid),
		.res       (res)
	);

	snml_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (!out_stall),
		.not_empty (out_valid),
		.head      (head),
		.count     (count)
	);

	assign event_kind      = head.event_kind;
	assign ack_dest        = head.ack_dest;
	assign ack_source      = head.ack_source;
	assign ack_sensor_kind = head.ack_sensor_kind;
	assign ack_sequence    = head.ack_sequence;
	assign reading_analog  = head.reading_analog;
	assign reading_channel = head.reading_channel;
	assign reading_value   = head.reading_value;
	assign total_bytes     = head.total_bytes;
	assign next_state      = head.next_state;

endmodule

>>> rtl/snml_checker.sv
// Port-level checks for the star network master link top level, with its bind.
// Depends on snml_pkg and star_net_master_link_fsm_top.
`timescale 1ns / 1ps

module snml_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_kind,
	input logic [7:0]  ack_dest,
	input logic [15:0] reading_value,
	input logic [1:0]  next_state
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_ack_to_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == snml_pkg::EV_SEND_ACK) |->
		(next_state == snml_pkg::ST_TRANSMIT) && (ack_dest != 8'd0))
		else $error("ack without move to transmit");

	a_read_to_rx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == snml_pkg::EV_READING) |->
		(next_state == snml_pkg::ST_RECEIVE))
		else $error("reading without move to receive");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind != snml_pkg::EV_SEND_ACK) &&
		(event_kind != snml_pkg::EV_READING) |->
		(ack_dest == 8'd0) && (reading_value == 16'd0))
		else $error("stray ack or reading data");

endmodule

bind star_net_master_link_fsm_top snml_checker u_snml_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.event_kind    (event_kind),
	.ack_dest      (ack_dest),
	.reading_value (reading_value),
	.next_state    (next_state)
);

>>> tb/star_net_master_link_fsm_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for star_net_master_link_fsm_top: directed and random link events are
// predicted transaction by transaction and every report is compared field by field.
// Depends on snml_pkg and the RTL top level; reads and writes no files.

module star_net_master_link_fsm_top_tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_AFTER    = 150;
	localparam int HOLD_CYCLES   = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	snml_pkg::item_t in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_kind;
	logic [7:0]  ack_dest;
	logic [7:0]  ack_source;
	logic [7:0]  ack_sensor_kind;
	logic [7:0]  ack_sequence;
	logic        reading_analog;
	logic        reading_channel;
	logic [15:0] reading_value;
	logic [15:0] total_bytes;
	logic [1:0]  next_state;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predicted link state, starting from the reset values
	logic [1:0]  cur_state = snml_pkg::ST_RESET;
	logic        rx_seen = 1'b0;
	logic        tx_seen = 1'b0;
	logic        crc_seen = 1'b0;
	logic [7:0]  hold_len = '0;
	logic [7:0]  hold_dest = '0;
	logic [7:0]  hold_src = '0;
	logic [7:0]  hold_kind = '0;
	logic [7:0]  hold_seq = '0;
	logic [7:0]  hold_chan = '0;
	logic [15:0] hold_val = '0;
	logic [15:0] rx_ticks = '0;
	logic [15:0] tx_ticks = '0;
	logic [15:0] bytes_sum = '0;
	logic [7:0]  my_addr = snml_pkg::RST_MASTER_ADDRESS;
	logic [7:0]  slave_max = snml_pkg::RST_SLAVE_COUNT;
	logic [15:0] rx_limit = snml_pkg::RST_RX_WAIT_TICKS;
	logic [15:0] tx_limit = snml_pkg::RST_TX_WAIT_TICKS;

	snml_pkg::item_t link_events[$];
	snml_pkg::res_t  link_reports[$];
	int    mismatch_count = 0;
	int    queued_items = 0;
	int    reports_seen = 0;
	int    stall_run = 0;
	bit    hold_done = 1'b0;
	bit    no_gaps = 1'b0;

	star_net_master_link_fsm_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(in_item.opcode),
		.crc_bad(in_item.crc_bad),
		.frame_length(in_item.frame_length),
		.frame_dest(in_item.frame_dest),
		.frame_source(in_item.frame_source),
		.frame_sensor_kind(in_item.frame_sensor_kind),
		.frame_sequence(in_item.frame_sequence),
		.frame_channel(in_item.frame_channel),
		.frame_value(in_item.frame_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.ack_dest(ack_dest),
		.ack_source(ack_source),
		.ack_sensor_kind(ack_sensor_kind),
		.ack_sequence(ack_sequence),
		.reading_analog(reading_analog),
		.reading_channel(reading_channel),
		.reading_value(reading_value),
		.total_bytes(total_bytes),
		.next_state(next_state),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic step_link(input snml_pkg::item_t ev);
		snml_pkg::res_t rep;
		logic fired;
		rep = '0;
		fired = 1'b0;
		case (ev.opcode)
			snml_pkg::OP_FRAME: begin
				rx_seen   = 1'b1;
				crc_seen  = crc_seen | ev.crc_bad;
				hold_len  = ev.frame_length;
				hold_dest = ev.frame_dest;
				hold_src  = ev.frame_source;
				hold_kind = ev.frame_sensor_kind;
				hold_seq  = ev.frame_sequence;
				hold_chan = ev.frame_channel;
				hold_val  = ev.frame_value;
			end
			snml_pkg::OP_TX_DONE: tx_seen = 1'b1;
			snml_pkg::OP_TICK: begin
				// both waits count on every tick and stick at full scale
				if (rx_ticks != snml_pkg::TIMER_MAX)
					rx_ticks = rx_ticks + 16'd1;
				if (tx_ticks != snml_pkg::TIMER_MAX)
					tx_ticks = tx_ticks + 16'd1;
				fired = 1'b1;
				case (cur_state)
					snml_pkg::ST_RESET: begin
						rx_seen = 1'b0;
						rx_ticks = '0;
						cur_state = snml_pkg::ST_RECEIVE;
						rep.event_kind = snml_pkg::EV_START_RX;
					end
					snml_pkg::ST_RECEIVE: begin
						if (!crc_seen && rx_seen && hold_len == snml_pkg::FRAME_BYTES &&
						    hold_dest == my_addr && hold_src != 8'd0 &&
						    hold_src <= slave_max) begin
							rx_seen = 1'b0;
							tx_seen = 1'b0;
							tx_ticks = '0;
							cur_state = snml_pkg::ST_TRANSMIT;
							rep.event_kind = snml_pkg::EV_SEND_ACK;
							rep.ack_dest = hold_src;
							rep.ack_source = my_addr;
							rep.ack_sensor_kind = hold_kind;
							rep.ack_sequence = hold_seq;
						end else if (crc_seen) begin
							rx_seen = 1'b0;
							crc_seen = 1'b0;
							cur_state = snml_pkg::ST_RESET;
							rep.event_kind = snml_pkg::EV_CRC_ERROR;
						end else if (!rx_seen && rx_ticks >= rx_limit) begin
							rx_ticks = '0;
							rep.event_kind = snml_pkg::EV_RX_WAIT;
						end else begin
							fired = 1'b0;
						end
					end
					default: begin
						if (tx_seen) begin
							tx_seen = 1'b0;
							bytes_sum = bytes_sum + {8'd0, snml_pkg::FRAME_BYTES};
							rx_ticks = '0;
							cur_state = snml_pkg::ST_RECEIVE;
							rep.event_kind = snml_pkg::EV_READING;
							rep.reading_analog = (hold_kind != 8'd0);
							rep.reading_channel = (hold_chan != 8'd0);
							rep.reading_value = hold_val;
						end else if (tx_ticks >= tx_limit) begin
							cur_state = snml_pkg::ST_RESET;
							rep.event_kind = snml_pkg::EV_TX_GIVEUP;
						end else begin
							fired = 1'b0;
						end
					end
				endcase
			end
			default: ;
		endcase
		if (fired) begin
			rep.total_bytes = bytes_sum;
			rep.next_state = cur_state;
			link_reports.push_back(rep);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
	                           input logic [15:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
			         $time, name, want, got);
		end
	endtask

	// sender: mirror config writes, predict each accepted event, offer the next pending event, hold it while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					snml_pkg::CFG_MASTER_ADDRESS: my_addr = cfg_data[7:0];
					snml_pkg::CFG_SLAVE_COUNT:    slave_max = cfg_data[7:0];
					snml_pkg::CFG_RX_WAIT_TICKS:  rx_limit = cfg_data;
					default:                      tx_limit = cfg_data;
				endcase
			end
			if (in_valid && !in_stall)
				step_link(in_item);
			if (!in_valid || !in_stall) begin
				if (link_events.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 9)) begin
					in_item <= link_events.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each report and drive out_stall
	always @(posedge clk) begin : report_check
		snml_pkg::res_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				reports_seen++;
				if (link_reports.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: unexpected report, expected none, actual kind %0h state %0h",
					         $time, event_kind, next_state);
				end else begin
					want = link_reports.pop_front();
					check_field("event_kind", 16'(want.event_kind), 16'(event_kind));
					check_field("ack_dest", 16'(want.ack_dest), 16'(ack_dest));
					check_field("ack_source", 16'(want.ack_source), 16'(ack_source));
					check_field("ack_sensor_kind", 16'(want.ack_sensor_kind),
					            16'(ack_sensor_kind));
					check_field("ack_sequence", 16'(want.ack_sequence), 16'(ack_sequence));
					check_field("reading_analog", 16'(want.reading_analog),
					            16'(reading_analog));
					check_field("reading_channel", 16'(want.reading_channel),
					            16'(reading_channel));
					check_field("reading_value", want.reading_value, reading_value);
					check_field("total_bytes", want.total_bytes, total_bytes);
					check_field("next_state", 16'(want.next_state), 16'(next_state));
				end
				// one long hold-off so the result queue fills and the input backs up
				if (!hold_done && reports_seen == HOLD_AFTER) begin
					hold_done = 1'b1;
					stall_run = HOLD_CYCLES;
				end
			end
			if (stall_run > 0) begin
				stall_run--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !no_gaps && ($urandom_range(0, 99) < 9);
			end
		end
	end

	function automatic snml_pkg::item_t random_event(input logic [1:0] op);
		snml_pkg::item_t ev;
		ev.opcode = op;
		ev.crc_bad = 1'($urandom_range(0, 1));
		ev.frame_length = 8'($urandom);
		ev.frame_dest = 8'($urandom);
		ev.frame_source = 8'($urandom);
		ev.frame_sensor_kind = 8'($urandom);
		ev.frame_sequence = 8'($urandom);
		ev.frame_channel = 8'($urandom);
		ev.frame_value = 16'($urandom);
		return ev;
	endfunction

	function automatic snml_pkg::item_t frame_of(input logic crc, input logic [7:0] len, dest,
	                                   src, kind, seq, chan, input logic [15:0] value);
		snml_pkg::item_t ev;
		ev = '{snml_pkg::OP_FRAME, crc, len, dest, src, kind, seq, chan, value};
		return ev;
	endfunction

	function automatic snml_pkg::item_t good_frame();
		snml_pkg::item_t ev;
		ev = random_event(snml_pkg::OP_FRAME);
		ev.crc_bad = 1'b0;
		ev.frame_length = snml_pkg::FRAME_BYTES;
		ev.frame_dest = my_addr;
		if (slave_max != 8'd0)
			ev.frame_source = 8'($urandom_range(1, slave_max));
		return ev;
	endfunction

	// clean frame with one header fault (a zero slave count adds a source fault)
	function automatic snml_pkg::item_t bad_frame();
		snml_pkg::item_t ev;
		ev = good_frame();
		case ($urandom_range(0, 2))
			0: begin
				ev.frame_length = 8'($urandom_range(0, 254));
				if (ev.frame_length >= snml_pkg::FRAME_BYTES)
					ev.frame_length = ev.frame_length + 8'd1;
			end
			1: ev.frame_dest = my_addr ^ 8'($urandom_range(1, 255));
			default: begin
				if (slave_max == 8'hFF || $urandom_range(0, 1) == 0)
					ev.frame_source = 8'd0;
				else
					ev.frame_source = 8'($urandom_range(int'(slave_max) + 1, 255));
			end
		endcase
		return ev;
	endfunction

	task automatic queue_event(input snml_pkg::item_t ev);
		link_events.push_back(ev);
		if (ev.opcode != OP_UNUSED)
			queued_items++;
	endtask

	task automatic add_ticks(input int n);
		int i;
		for (i = 0; i < n; i++)
			queue_event(random_event(snml_pkg::OP_TICK));
	endtask

	task automatic add_random(input int count);
		int stop;
		int pick;
		snml_pkg::item_t ev;
		stop = queued_items + count;
		while (queued_items < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// full exchange: open, frame, acknowledge, transmit done, reading
				add_ticks(1);
				queue_event(good_frame());
				add_ticks(1 + $urandom_range(0, 2));
				queue_event(random_event(snml_pkg::OP_TX_DONE));
				add_ticks(1);
			end else if (pick < 58) begin
				// a late frame replaces the held one before the reading
				add_ticks(1);
				queue_event(good_frame());
				add_ticks(1);
				queue_event(random_event(snml_pkg::OP_FRAME));
				queue_event(random_event(snml_pkg::OP_TX_DONE));
				add_ticks(1);
			end else if (pick < 66) begin
				add_ticks(1);
				ev = random_event(snml_pkg::OP_FRAME);
				ev.crc_bad = 1'b1;
				queue_event(ev);
				if ($urandom_range(0, 1) == 1)
					queue_event(good_frame());
				add_ticks(1);
			end else if (pick < 74) begin
				add_ticks(1);
				queue_event(bad_frame());
				add_ticks(2);
			end else if (pick < 80) begin
				add_ticks(rx_limit <= 16'd24 ? int'(rx_limit) + 1 : 3);
			end else if (pick < 86) begin
				add_ticks(1);
				queue_event(good_frame());
				add_ticks(1 + (tx_limit <= 16'd24 ? int'(tx_limit) : 3));
			end else if (pick < 94) begin
				queue_event(random_event(2'($urandom_range(0, 2))));
			end else begin
				queue_event(random_event(OP_UNUSED));
			end
		end
	endtask

	task automatic write_settings(input logic [7:0] addr, slaves, input logic [15:0] rxw, txw);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= snml_pkg::CFG_MASTER_ADDRESS;
		cfg_data <= {8'($urandom), addr};
		@(posedge clk);
		cfg_index <= snml_pkg::CFG_SLAVE_COUNT;
		cfg_data <= {8'($urandom), slaves};
		@(posedge clk);
		cfg_index <= snml_pkg::CFG_RX_WAIT_TICKS;
		cfg_data <= rxw;
		@(posedge clk);
		cfg_index <= snml_pkg::CFG_TX_WAIT_TICKS;
		cfg_data <= txw;
		@(posedge clk);
		cfg_we <= 1'b0;
		// let the last write reach the predictor before new events are built
		@(posedge clk);
	endtask

	// drain: nothing pending, nothing in flight, nothing expected, then settle
	task automatic wait_idle();
		@(posedge clk);
		while (link_events.size() != 0 || in_valid || link_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("star_net_master_link_fsm_top regression: fail");
		$finish;
	end

	initial begin : stimulus
		snml_pkg::item_t ev;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed, under the reset register values
		queue_event(random_event(snml_pkg::OP_TICK));
		queue_event(frame_of(1'b0, 8'd8, 8'h00, 8'd3, 8'h00, 8'h00, 8'h00, 16'h0000));
		queue_event(random_event(snml_pkg::OP_TICK));
		queue_event(random_event(snml_pkg::OP_TX_DONE));
		queue_event(random_event(snml_pkg::OP_TICK));
		// source above the slave count, then source zero, then wrong length and address
		queue_event(frame_of(1'b0, 8'd8, 8'h00, 8'd4, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
		queue_event(random_event(snml_pkg::OP_TICK));
		queue_event(frame_of(1'b0, 8'd8, 8'h00, 8'd0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
		queue_event(random_event(snml_pkg::OP_TICK));
		queue_event(frame_of(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 16'h8001));
		queue_event(random_event(snml_pkg::OP_TICK));
		queue_event(frame_of(1'b0, 8'd8, 8'h00, 8'd1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
		queue_event(random_event(snml_pkg::OP_TICK));
		queue_event(random_event(snml_pkg::OP_TICK));
		// late frame while transmitting: the reading reports the replacement
		queue_event(frame_of(1'b0, 8'd0, 8'h55, 8'hAA, 8'h80, 8'h5A, 8'h01, 16'h1234));
		queue_event(random_event(snml_pkg::OP_TX_DONE));
		queue_event(random_event(snml_pkg::OP_TICK));
		// unknown opcode with every payload bit set is dropped
		ev = '1;
		queue_event(ev);
		// CRC flag sticks across a following clean frame
		queue_event(frame_of(1'b1, 8'd8, 8'h00, 8'd2, 8'h00, 8'h11, 8'h00, 16'h00FF));
		queue_event(frame_of(1'b0, 8'd8, 8'h00, 8'd2, 8'h00, 8'h22, 8'h00, 16'hFF00));
		queue_event(random_event(snml_pkg::OP_TICK));
		queue_event(random_event(snml_pkg::OP_TICK));
		// stale transmit done is cleared by the acknowledge
		queue_event(random_event(snml_pkg::OP_TX_DONE));
		queue_event(frame_of(1'b0, 8'd8, 8'h00, 8'd3, 8'h7F, 8'h80, 8'h00, 16'h4321));
		queue_event(random_event(snml_pkg::OP_TICK));
		queue_event(random_event(snml_pkg::OP_TICK));
		wait_idle();

		write_settings(8'hFF, 8'hFF, 16'd1, 16'd1);
		add_random(240);
		wait_idle();

		write_settings(8'h00, 8'h00, 16'd3, 16'd2);
		add_random(160);
		wait_idle();

		write_settings(8'($urandom), 8'($urandom_range(1, 255)),
		               16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
		add_random(250);
		wait_idle();

		// stretch with no idling on either side
		no_gaps = 1'b1;
		write_settings(8'($urandom), 8'($urandom_range(1, 255)),
		               16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)));
		add_random(300);
		wait_idle();
		no_gaps = 1'b0;

		write_settings(8'($urandom), 8'd1, 16'd2, 16'd5);
		add_random(250);
		wait_idle();

		if (mismatch_count == 0)
			$display("star_net_master_link_fsm_top regression: pass");
		else
			$display("star_net_master_link_fsm_top regression: fail");
		$finish;
	end

endmodule
